// ===== src/stfd_pkg.sv =====
// Shared types and constants of the two-rail track frame decoder.
// No dependencies; the front, the back and the top of the decoder import this package.
package stfd_pkg;

  // Channel table and frame layout
  localparam int CHANNELS_DEFAULT = 112;
  localparam int FRAMES           = 7;
  localparam int CH_W             = 7;
  localparam int BYTE_W           = 8;

  // Queue depths between the parts
  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  // Item operation codes
  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration register indexes
  localparam logic REG_SCOPE_ENABLE    = 1'b0;
  localparam logic REG_TRIGGER_CHANNEL = 1'b1;

  typedef enum logic [1:0] {
    PH_SYNC = 2'd0,
    PH_ADDR = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  // What the front hands to the back for one item
  typedef enum logic [1:0] {
    KIND_NOP  = 2'd0,
    KIND_BIT  = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              bit_val;
    logic [CH_W-1:0]   read_channel;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              write_valid;
    logic [CH_W-1:0]   write_channel;
    logic [BYTE_W-1:0] write_data;
    logic              scope_level;
    phase_t            decoder_phase;
  } res_t;

  typedef struct packed {
    logic            scope_enable;
    logic [CH_W-1:0] trigger_channel;
  } cfg_t;

endpackage

// ===== src/stfd_fifo.sv =====
// Small first-in first-out queue of flat words, flip-flop storage.
// No dependencies; used for the command queue and the result queue.
module stfd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             push_data,
  input  logic                         pop,
  output logic [WIDTH-1:0]             pop_data,
  output logic                         full,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    if (p == PW'(DEPTH - 1)) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  // Store incoming word at the tail
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== src/stfd_front.sv =====
// Front part: accepts items, turns rail levels into track bits, queues commands.
// Depends on stfd_pkg and stfd_fifo.
module stfd_front import stfd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic            operation,
  input  logic            rail_one_level,
  input  logic            rail_two_level,
  input  logic [CH_W-1:0] read_channel,
  input  logic            cmd_pop,
  output cmd_t            cmd,
  output logic            cmd_empty
);

  logic                accept;
  logic                rail_valid;
  logic                last_polarity;
  cmd_t                cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_bits;

  assign accept     = push && !full;
  assign rail_valid = (rail_one_level != rail_two_level);

  // Classify the word: read, track bit, or edge with both rails equal
  always_comb begin
    cmd_in              = '0;
    cmd_in.read_channel = read_channel;
    if (operation == OP_READ) begin
      cmd_in.kind = KIND_READ;
    end else if (rail_valid) begin
      cmd_in.kind    = KIND_BIT;
      cmd_in.bit_val = (rail_one_level != last_polarity);
    end else begin
      cmd_in.kind = KIND_NOP;
    end
  end

  // Track polarity of the last valid edge
  always_ff @(posedge clk) begin
    if (rst) begin
      last_polarity <= 1'b0;
    end else if (accept && operation == OP_EDGE && rail_valid) begin
      last_polarity <= rail_one_level;
    end
  end

  stfd_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cmd_in),
    .pop       (cmd_pop),
    .pop_data  (cmd_bits),
    .full      (full),
    .empty     (cmd_empty),
    .count     ()
  );

  assign cmd = cmd_t'(cmd_bits);

endmodule

// ===== src/stfd_back.sv =====
// Back part: frame decoder state machine, channel table and result stage.
// Depends on stfd_pkg.
module stfd_back import stfd_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  cmd_t              cmd,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  input  logic [OUT_CW-1:0] out_count,
  output logic              res_push,
  output res_t              res
);

  localparam int AW = $clog2(CHANNELS);
  localparam logic [3:0] POS_FIRST = 4'd0;
  localparam logic [3:0] POS_LAST  = 4'd11;

  // Decoder state
  phase_t      phase, phase_next;
  logic [2:0]  zero_run, zero_run_next;
  logic [3:0]  base_address, base_address_next;
  logic [2:0]  addr_idx, addr_idx_next;
  logic [2:0]  frame_idx, frame_idx_next;
  logic [3:0]  data_idx, data_idx_next;
  logic [7:0]  byte_shift, byte_shift_next;
  logic        trigger_level, trigger_level_next;

  // Channel table with per-entry valid bits
  logic [BYTE_W-1:0] chan_mem [CHANNELS];
  logic [CHANNELS-1:0] row_valid;
  logic [BYTE_W-1:0] mem_q;

  // Result stage
  logic              st_valid;
  logic              st_read;
  logic              st_hit;
  logic              st_wv;
  logic [CH_W-1:0]   st_wch;
  logic [BYTE_W-1:0] st_wdat;
  logic              st_scope;
  phase_t            st_phase;

  logic              fire;
  logic              b;
  logic              store;
  logic              wr_en;
  logic [CH_W-1:0]   chan;
  logic [2:0]        frame_inc;
  logic              rd_in_range;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;

  // Take a command only when the result queue has a slot left for it
  assign fire    = !cmd_empty &&
                   ((4'(out_count) + 4'(st_valid)) < 4'(OUT_DEPTH));
  assign cmd_pop = fire;
  assign b       = cmd.bit_val;

  // Channel of the current frame: low nibble from the base, high bits from the frame
  assign chan      = {3'(3'd6 - frame_idx), 4'(4'd15 - base_address)};
  assign frame_inc = frame_idx + 3'd1;

  assign rd_in_range = ({1'b0, cmd.read_channel} < 8'(CHANNELS));
  assign rd_addr     = cmd.read_channel[AW-1:0];
  assign wr_addr     = chan[AW-1:0];
  assign wr_en       = store && ({1'b0, chan} < 8'(CHANNELS));

  // Next decoder state for one track bit
  always_comb begin
    phase_next         = phase;
    zero_run_next      = zero_run;
    base_address_next  = base_address;
    addr_idx_next      = addr_idx;
    frame_idx_next     = frame_idx;
    data_idx_next      = data_idx;
    byte_shift_next    = byte_shift;
    trigger_level_next = trigger_level;
    store              = 1'b0;
    if (fire && cmd.kind == KIND_BIT) begin
      unique case (phase)
        PH_SYNC: begin
          if (!b) begin
            if (zero_run < 3'd4) begin
              zero_run_next = zero_run + 3'd1;
            end
          end else if (zero_run == 3'd3) begin
            phase_next        = PH_ADDR;
            base_address_next = '0;
            addr_idx_next     = '0;
          end else begin
            zero_run_next = '0;
          end
        end
        PH_ADDR: begin
          unique case (addr_idx)
            3'd2: base_address_next[3] = b;
            3'd3: base_address_next[2] = b;
            3'd5: base_address_next[1] = b;
            3'd6: base_address_next[0] = b;
            3'd7: begin
              phase_next      = PH_DATA;
              frame_idx_next  = '0;
              data_idx_next   = '0;
              byte_shift_next = '0;
            end
            default: ;
          endcase
          addr_idx_next = addr_idx + 3'd1;
        end
        PH_DATA: begin
          unique case (data_idx)
            // Separator positions must carry a one
            4'd2, 4'd5, 4'd8: begin
              if (b) begin
                data_idx_next = data_idx + 4'd1;
              end else begin
                frame_idx_next = '0;
                phase_next     = PH_SYNC;
                zero_run_next  = '0;
                data_idx_next  = '0;
              end
            end
            POS_FIRST: begin
              byte_shift_next = {7'd0, b};
              data_idx_next   = data_idx + 4'd1;
              if (cfg.scope_enable) begin
                trigger_level_next = (chan == cfg.trigger_channel);
              end
            end
            4'd1:  begin byte_shift_next[1] = b; data_idx_next = data_idx + 4'd1; end
            4'd3:  begin byte_shift_next[2] = b; data_idx_next = data_idx + 4'd1; end
            4'd4:  begin byte_shift_next[3] = b; data_idx_next = data_idx + 4'd1; end
            4'd6:  begin byte_shift_next[4] = b; data_idx_next = data_idx + 4'd1; end
            4'd7:  begin byte_shift_next[5] = b; data_idx_next = data_idx + 4'd1; end
            4'd9:  begin byte_shift_next[6] = b; data_idx_next = data_idx + 4'd1; end
            4'd10: begin byte_shift_next[7] = b; data_idx_next = data_idx + 4'd1; end
            // Last position: store the byte whatever the bit is
            POS_LAST: begin
              store = 1'b1;
              if (frame_inc == 3'(FRAMES)) begin
                frame_idx_next = '0;
                phase_next     = PH_SYNC;
                zero_run_next  = '0;
                data_idx_next  = '0;
              end else begin
                frame_idx_next  = frame_inc;
                data_idx_next   = '0;
                byte_shift_next = '0;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Hold decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SYNC;
      zero_run      <= '0;
      base_address  <= '0;
      addr_idx      <= '0;
      frame_idx     <= '0;
      data_idx      <= '0;
      byte_shift    <= '0;
      trigger_level <= 1'b0;
    end else begin
      phase         <= phase_next;
      zero_run      <= zero_run_next;
      base_address  <= base_address_next;
      addr_idx      <= addr_idx_next;
      frame_idx     <= frame_idx_next;
      data_idx      <= data_idx_next;
      byte_shift    <= byte_shift_next;
      trigger_level <= trigger_level_next;
    end
  end

  // Write completed bytes, read with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      chan_mem[wr_addr] <= byte_shift;
    end
    mem_q <= chan_mem[rd_addr];
  end

  // Mark written rows; unwritten rows read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  // Capture the result of the fired command
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else begin
      st_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      st_read  <= (cmd.kind == KIND_READ);
      st_hit   <= rd_in_range && row_valid[rd_addr];
      st_wv    <= store;
      st_wch   <= store ? chan : '0;
      st_wdat  <= store ? byte_shift : '0;
      st_scope <= trigger_level_next;
      st_phase <= phase_next;
    end
  end

  // Assemble the result word
  always_comb begin
    res               = '0;
    res.read_data     = (st_read && st_hit) ? mem_q : '0;
    res.write_valid   = st_wv;
    res.write_channel = st_wch;
    res.write_data    = st_wdat;
    res.scope_level   = st_scope;
    res.decoder_phase = st_phase;
  end

  assign res_push = st_valid;

endmodule

// ===== src/selectrix_track_frame_decoder_top.sv =====
// Two-rail track frame decoder: front classifier, command queue, decoder back, result queue.
// Path: an accepted word passes the command queue, the result stage and the result queue before it is poppable.
// Throughput: one word per cycle while the result queue has room, set by the decoder update and table port.
// Reset: decoder state and configuration cleared; table rows marked unwritten (read 0).
// No clearing pass after reset; full and empty are valid as soon as reset is released.
// Depends on stfd_pkg, stfd_fifo, stfd_front and stfd_back.
module selectrix_track_frame_decoder_top import stfd_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              operation,
  input  logic              rail_one_level,
  input  logic              rail_two_level,
  input  logic [CH_W-1:0]   read_channel,
  output logic              empty,
  input  logic              pop,
  output logic [BYTE_W-1:0] read_data,
  output logic              write_valid,
  output logic [CH_W-1:0]   write_channel,
  output logic [BYTE_W-1:0] write_data,
  output logic              scope_level,
  output logic [1:0]        decoder_phase,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [CH_W-1:0]   cfg_data
);

  cfg_t              cfg;
  cmd_t              cmd;
  logic              cmd_empty;
  logic              cmd_pop;
  res_t              res;
  logic              res_push;
  logic [OUT_CW-1:0] out_count;
  logic [$bits(res_t)-1:0] out_bits;
  res_t              out_word;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCOPE_ENABLE:    cfg.scope_enable    <= cfg_data[0];
        REG_TRIGGER_CHANNEL: cfg.trigger_channel <= cfg_data;
        default: ;
      endcase
    end
  end

  stfd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .operation      (operation),
    .rail_one_level (rail_one_level),
    .rail_two_level (rail_two_level),
    .read_channel   (read_channel),
    .cmd_pop        (cmd_pop),
    .cmd            (cmd),
    .cmd_empty      (cmd_empty)
  );

  stfd_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_count (out_count),
    .res_push  (res_push),
    .res       (res)
  );

  stfd_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .pop       (pop),
    .pop_data  (out_bits),
    .full      (),
    .empty     (empty),
    .count     (out_count)
  );

  // Drive result ports from the queue head
  assign out_word      = res_t'(out_bits);
  assign read_data     = out_word.read_data;
  assign write_valid   = out_word.write_valid;
  assign write_channel = out_word.write_channel;
  assign write_data    = out_word.write_data;
  assign scope_level   = out_word.scope_level;
  assign decoder_phase = out_word.decoder_phase;

  // The back reserves a slot, so a result never meets a full queue
  assert property (@(posedge clk) disable iff (rst)
    res_push |-> (out_count < OUT_CW'(OUT_DEPTH)))
    else $error("result pushed into full queue");

  // A reported write targets a table row
  assert property (@(posedge clk) disable iff (rst)
    (!empty && write_valid) |-> ({1'b0, write_channel} < 8'(CHANNELS)))
    else $error("write reported outside the table");

  // A byte completes only in the data phase, leaving data or sync
  assert property (@(posedge clk) disable iff (rst)
    (!empty && write_valid) |-> (decoder_phase != PH_ADDR))
    else $error("write reported while in address phase");

  // Write reports and read data never share one word
  assert property (@(posedge clk) disable iff (rst)
    (!empty && write_valid) |-> (read_data == '0))
    else $error("read data on an edge word");

endmodule
